// File: rtl/core/edm_pkg.sv
package edm_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 24;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned DIST_W = 26;

  // pi * 2^61 / 1.8e9, maps |lat_a + lat_b| to the mean latitude in Q30 radians
  localparam logic [31:0] ANGLE_MUL   = 32'd4024455254;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  // inverse cordic gain, Q30
  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  // 0.011132 * 2^32, metres per 1e-7 degree
  localparam logic [25:0] METRE_MUL   = 26'd47811576;
  localparam logic [DIST_W-1:0] OUT_MAX = '1;

  // arctangent of 2^-i in Q30
  function automatic logic [31:0] edm_atan(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/edm_rot_cell.sv
module edm_rot_cell
  import edm_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned XW  = 34,
  parameter int unsigned ZW  = 34,
  parameter int unsigned PW  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic [PW-1:0]        pay_o
);

  logic                 v_q;
  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] at, z_d, z_q;
  logic [PW-1:0]        pay_q;

  assign in_ready_o = !v_q || out_ready_i;

  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    at = $signed({{(ZW-32){1'b0}}, edm_atan(5'(IDX))});
    if (!z_i[ZW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - at;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      pay_q <= pay_i;
    end
  end

  assign out_valid_o = v_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign pay_o = pay_q;

endmodule

// File: rtl/core/edm_vec_cell.sv
module edm_vec_cell
  import edm_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned VW  = 45
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [VW-1:0] x_i,
  input  logic signed [VW-1:0] y_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [VW-1:0] x_o,
  output logic signed [VW-1:0] y_o
);

  logic                 v_q;
  logic signed [VW-1:0] xs, ys, x_d, y_d, x_q, y_q;

  assign in_ready_o = !v_q || out_ready_i;

  // drive y toward zero, x collects the scaled magnitude
  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    if (!y_i[VW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign out_valid_o = v_q;
  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// File: rtl/core/equirect_distance_metres.sv
// equirectangular distance between two points, whole metres
// input channel: in_valid_i / in_ready_o, one transfer carries point a and
//   point b (lat_*_i, lon_*_i in 1e-7 degree, two's complement)
// output channel: out_valid_o / out_ready_i, one transfer per input transfer,
//   distance_metres_o rounded to nearest, saturating at 2^26 - 1
// structure: two rows of cordic cells, one for the cosine of the mean latitude
//   and one for the vector magnitude, plus ten stages of difference, multiply,
//   clamp and round around them
// throughput: one transfer per cycle while out_ready_i stays high; every stage
//   of the chain holds its own valid bit and hands data on whenever the next stage is free
// stall: when out_ready_i is low the result stays in the output register and
//   earlier stages keep filling bubbles; in_ready_o falls only once every
//   stage holds an item
// reset: all valid bits clear and the pipeline is empty; data registers are not reset
module equirect_distance_metres
  import edm_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic signed [30:0] lat_a_i,
  input  logic signed [31:0] lon_a_i,
  input  logic signed [30:0] lat_b_i,
  input  logic signed [31:0] lon_b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DIST_W-1:0] distance_metres_o
);

  localparam int unsigned N   = CORDIC_STAGES;
  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned SH  = 32 - F;
  // metres in Q.F, enough for a 2^32 longitude step
  localparam int unsigned XMW = F + 26;
  localparam int unsigned XW  = 34;
  localparam int unsigned ZW  = 34;
  localparam int unsigned VW  = F + 29;
  localparam int unsigned PW1 = F + 58;
  localparam int unsigned PW2 = F + 59;

  localparam logic [58:0] MHALF = 59'(1) << (SH - 1);
  localparam logic signed [XW-1:0] COS_ONE = XW'(64'd1 << 30);

  // stage valid bits and ready chain
  logic [9:0] v_q;
  logic r0, r1, r2, r3, r4, r5, r6, r7, r8, r9;

  logic [N:0] rot_v, rot_r, vec_v, vec_r;
  logic signed [XW-1:0] rx [0:N];
  logic signed [XW-1:0] ry [0:N];
  logic signed [ZW-1:0] rz [0:N];
  logic [2*XMW-1:0]     rp [0:N];
  logic signed [VW-1:0] vx [0:N];
  logic signed [VW-1:0] vy [0:N];

  assign r9 = !v_q[9] || out_ready_i;
  assign r8 = !v_q[8] || r9;
  assign r7 = !v_q[7] || r8;
  assign r6 = !v_q[6] || r7;
  assign vec_r[N] = r6;
  assign r5 = !v_q[5] || vec_r[0];
  assign r4 = !v_q[4] || r5;
  assign r3 = !v_q[3] || r4;
  assign rot_r[N] = r3;
  assign r2 = !v_q[2] || rot_r[0];
  assign r1 = !v_q[1] || r2;
  assign r0 = !v_q[0] || r1;
  assign in_ready_o = r0;

  assign rot_v[0] = v_q[2];
  assign vec_v[0] = v_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (r0) v_q[0] <= in_valid_i;
      if (r1) v_q[1] <= v_q[0];
      if (r2) v_q[2] <= v_q[1];
      if (r3) v_q[3] <= rot_v[N];
      if (r4) v_q[4] <= v_q[3];
      if (r5) v_q[5] <= v_q[4];
      if (r6) v_q[6] <= vec_v[N];
      if (r7) v_q[7] <= v_q[6];
      if (r8) v_q[8] <= v_q[7];
      if (r9) v_q[9] <= v_q[8];
    end
  end

  // stage 0: exact differences and latitude sum, magnitudes only
  logic [31:0] lsum_w, ldif_w;
  logic [32:0] odif_w;
  logic [31:0] sum0_q, dlat0_q;
  logic [32:0] dlon0_q;

  always_comb begin
    lsum_w = {lat_a_i[30], lat_a_i} + {lat_b_i[30], lat_b_i};
    ldif_w = {lat_b_i[30], lat_b_i} - {lat_a_i[30], lat_a_i};
    odif_w = {lon_b_i[31], lon_b_i} - {lon_a_i[31], lon_a_i};
  end

  always_ff @(posedge clk_i) begin
    if (r0) begin
      sum0_q  <= lsum_w[31] ? (32'd0 - lsum_w) : lsum_w;
      dlat0_q <= ldif_w[31] ? (32'd0 - ldif_w) : ldif_w;
      dlon0_q <= odif_w[32] ? (33'd0 - odif_w) : odif_w;
    end
  end

  // stage 1: angle of the mean latitude, both differences to metres
  logic [63:0] ang_w;
  logic [58:0] ym_w, xm_w;
  logic [31:0] ang1_q;
  logic [XMW-1:0] xm1_q, ym1_q;

  always_comb begin
    ang_w = 64'(sum0_q) * 64'(ANGLE_MUL) + 64'h8000_0000;
    ym_w  = 59'(dlat0_q) * 59'(METRE_MUL) + MHALF;
    xm_w  = 59'(dlon0_q) * 59'(METRE_MUL) + MHALF;
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      ang1_q <= ang_w[63:32];
      ym1_q  <= ym_w[XMW-1+SH:SH];
      xm1_q  <= xm_w[XMW-1+SH:SH];
    end
  end

  // stage 2: fold into the first quadrant, |cos| is symmetric about pi/2
  logic signed [ZW-1:0] z2_q;
  logic [XMW-1:0] xm2_q, ym2_q;

  always_ff @(posedge clk_i) begin
    if (r2) begin
      z2_q  <= $signed({2'b00, (ang1_q > HALF_PI_Q30) ? (PI_Q30 - ang1_q) : ang1_q});
      xm2_q <= xm1_q;
      ym2_q <= ym1_q;
    end
  end

  assign rx[0] = $signed(XW'(GAIN_Q30));
  assign ry[0] = '0;
  assign rz[0] = z2_q;
  assign rp[0] = {xm2_q, ym2_q};

  // rotation row: cosine of the mean latitude
  for (genvar i = 0; i < N; i++) begin : g_rot
    edm_rot_cell #(
      .IDX(i), .XW(XW), .ZW(ZW), .PW(2*XMW)
    ) u_rot (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (rot_v[i]),
      .in_ready_o (rot_r[i]),
      .x_i        (rx[i]),
      .y_i        (ry[i]),
      .z_i        (rz[i]),
      .pay_i      (rp[i]),
      .out_valid_o(rot_v[i+1]),
      .out_ready_i(rot_r[i+1]),
      .x_o        (rx[i+1]),
      .y_o        (ry[i+1]),
      .z_o        (rz[i+1]),
      .pay_o      (rp[i+1])
    );
  end

  // stage 3: clamp cosine to [0, 1] in q1.30
  logic [30:0] c3_q;
  logic [XMW-1:0] xm3_q, ym3_q;

  always_ff @(posedge clk_i) begin
    if (r3) begin
      if (rx[N][XW-1]) begin
        c3_q <= '0;
      end else if (rx[N] > COS_ONE) begin
        c3_q <= 31'h4000_0000;
      end else begin
        c3_q <= rx[N][30:0];
      end
      xm3_q <= rp[N][2*XMW-1:XMW];
      ym3_q <= rp[N][XMW-1:0];
    end
  end

  // stage 4: longitude metres times cosine, split into two products
  logic [F+30:0] hi4_q;
  logic [56:0]   lo4_q;
  logic [XMW-1:0] ym4_q;

  always_ff @(posedge clk_i) begin
    if (r4) begin
      hi4_q <= (F+31)'(xm3_q[XMW-1:26]) * (F+31)'(c3_q);
      lo4_q <= 57'(xm3_q[25:0]) * 57'(c3_q);
      ym4_q <= ym3_q;
    end
  end

  // stage 5: recombine, round half up
  logic [PW1-1:0] p5_w;
  logic signed [VW-1:0] x5_q, y5_q;

  assign p5_w = {1'b0, hi4_q, 26'd0} + PW1'(lo4_q) + (PW1'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (r5) begin
      x5_q <= $signed({3'b000, p5_w[XMW+29:30]});
      y5_q <= $signed({3'b000, ym4_q});
    end
  end

  assign vx[0] = x5_q;
  assign vy[0] = y5_q;

  // vectoring row: magnitude of (xm, ym)
  for (genvar i = 0; i < N; i++) begin : g_vec
    edm_vec_cell #(
      .IDX(i), .VW(VW)
    ) u_vec (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (vec_v[i]),
      .in_ready_o (vec_r[i]),
      .x_i        (vx[i]),
      .y_i        (vy[i]),
      .out_valid_o(vec_v[i+1]),
      .out_ready_i(vec_r[i+1]),
      .x_o        (vx[i+1]),
      .y_o        (vy[i+1])
    );
  end

  // stage 6: clamp at zero
  logic [VW-2:0] x6_q;

  always_ff @(posedge clk_i) begin
    if (r6) begin
      x6_q <= vx[N][VW-1] ? '0 : vx[N][VW-2:0];
    end
  end

  // stage 7: gain correction, split into two products
  logic [F+31:0] hi7_q;
  logic [55:0]   lo7_q;

  always_ff @(posedge clk_i) begin
    if (r7) begin
      hi7_q <= (F+32)'(x6_q[VW-2:26]) * (F+32)'(GAIN_Q30);
      lo7_q <= 56'(x6_q[25:0]) * 56'(GAIN_Q30);
    end
  end

  // stage 8: recombine, round half up
  logic [PW2-1:0] p8_w;
  logic [PW2-31:0] mag8_q;

  assign p8_w = {1'b0, hi7_q, 26'd0} + PW2'(lo7_q) + (PW2'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (r8) begin
      mag8_q <= p8_w[PW2-1:30];
    end
  end

  // stage 9: round to whole metres, saturate
  logic [PW2-30:0] rnd_w;
  logic [PW2-30-F:0] d_w;
  logic [DIST_W-1:0] dist9_q;

  always_comb begin
    rnd_w = {1'b0, mag8_q} + ((PW2-29)'(1) << (F - 1));
    d_w   = rnd_w[PW2-30:F];
  end

  always_ff @(posedge clk_i) begin
    if (r9) begin
      dist9_q <= (d_w > (PW2-29-F)'(OUT_MAX)) ? OUT_MAX : d_w[DIST_W-1:0];
    end
  end

  assign out_valid_o       = v_q[9];
  assign distance_metres_o = dist9_q;

endmodule
